/* rtl/frustum_box_sphere_cull_macros.svh */
// ----------------------------------------------------------------------------
// frustum cull assertion macros
// Concurrent assertion helpers clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_SPHERE_CULL_MACROS_SVH
`define FRUSTUM_BOX_SPHERE_CULL_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define FBSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);
// expression must never be true out of reset
`define FBSC_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);
`else
`define FBSC_ASSERT(label, prop, msg)
`define FBSC_NEVER(label, expr, msg)
`endif

`endif

/* rtl/fbsc_pkg.sv */
// ----------------------------------------------------------------------------
// fbsc_pkg
// Shared constants and types for the frustum box and sphere cull pipeline.
// ----------------------------------------------------------------------------
package fbsc_pkg;

    // number of frustum planes held in configuration
    localparam int PLANE_COUNT = 4;
    // one clip-mask bit per plane
    localparam int CLIP_W      = PLANE_COUNT;

    // configuration register indexes
    localparam int CFG_IDX_W   = $clog2(PLANE_COUNT + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_NO_CULL = CFG_IDX_W'(PLANE_COUNT);

    // field formats
    localparam int COORD_W     = 16;
    localparam int NORM_W      = 12;
    localparam int DIST_W      = 28;
    localparam int DIST_LSB    = 3 * NORM_W;
    localparam int PLANE_W     = 64;
    localparam int FRAC_BITS   = 10;
    localparam int PROD_W      = NORM_W + COORD_W;
    // sum of three products plus the scaled radius, with headroom
    localparam int ACC_W       = PROD_W + 3;

    // stream payload widths
    localparam int S_TDATA_W   = 168;
    localparam int M_TDATA_W   = 8;

    // opcodes
    localparam logic OP_BOX    = 1'b0;
    localparam logic OP_SPHERE = 1'b1;

    // per-stage load enables for the plane datapaths
    typedef struct packed {
        logic sel;
        logic mul;
        logic sum;
    } fbsc_stage_en_t;

endpackage

/* rtl/frustum_box_sphere_cull.sv */
// ----------------------------------------------------------------------------
// frustum_box_sphere_cull
// Tests a box or a sphere against the enabled frustum planes.
// ----------------------------------------------------------------------------
// pipeline: select, multiply, sum, compare into the output register
// throughput: one item per cycle while the output is not stalled; every stage
//   moves on when the one after it is empty or moving, so bubbles close up
//   under an output stall
// reset: synchronous, active low; clears valid bits, planes and no_cull
// ----------------------------------------------------------------------------
`include "frustum_box_sphere_cull_macros.svh"

module frustum_box_sphere_cull
    import fbsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // center_x, center_y, center_z, radius, clip_mask, zero pad
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // culled, zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PLANE_W-1:0]    cfg_data
);

    logic [PLANE_W-1:0]        plane_reg [PLANE_COUNT];
    logic                      no_cull_reg;

    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    logic signed [COORD_W-1:0] ctr [3];
    logic [COORD_W-1:0]        radius;
    logic [CLIP_W-1:0]         clip_mask;

    logic                      v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic                      rdy1, rdy2, rdy3, rdy_out;
    fbsc_stage_en_t            en;

    logic [CLIP_W-1:0]         mask1_reg, mask2_reg, mask3_reg;
    logic signed [ACC_W-1:0]   lhs [PLANE_COUNT];
    logic signed [ACC_W-1:0]   rhs [PLANE_COUNT];
    logic [PLANE_COUNT-1:0]    outside;
    logic                      culled_reg;
    logic                      culled_next;

    // configuration writes, never stalled
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                plane_reg[i] <= '0;
            end
            no_cull_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    plane_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == CFG_NO_CULL) begin
                no_cull_reg <= cfg_data[0];
            end
        end
    end

    // unpack the input transfer
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lo[k]  = $signed(s_axis_tdata[k*COORD_W +: COORD_W]);
            hi[k]  = $signed(s_axis_tdata[(3+k)*COORD_W +: COORD_W]);
            ctr[k] = $signed(s_axis_tdata[(6+k)*COORD_W +: COORD_W]);
        end
        radius    = s_axis_tdata[9*COORD_W +: COORD_W];
        clip_mask = s_axis_tdata[10*COORD_W +: CLIP_W];
    end

    // stage handshake: a stage loads when it is empty or its item moves on
    assign rdy_out       = !out_valid_reg || m_axis_tready;
    assign rdy3          = !v3_reg || rdy_out;
    assign rdy2          = !v2_reg || rdy3;
    assign rdy1          = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;
    assign en.sel        = rdy1;
    assign en.mul        = rdy2;
    assign en.sum        = rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy_out) begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // clip mask travels beside the plane datapaths
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            mask1_reg <= clip_mask;
        end
        if (rdy2) begin
            mask2_reg <= mask1_reg;
        end
        if (rdy3) begin
            mask3_reg <= mask2_reg;
        end
    end

    // one datapath per plane
    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
        fbsc_plane u_plane (
            .aclk   (aclk),
            .en     (en),
            .plane  (plane_reg[i]),
            .opcode (s_axis_tuser),
            .lo     (lo),
            .hi     (hi),
            .ctr    (ctr),
            .radius (radius),
            .lhs    (lhs[i]),
            .rhs    (rhs[i])
        );
        assign outside[i] = lhs[i] < rhs[i];
    end

    // final stage: compare, mask and combine planes; no_cull forces not culled
    assign culled_next = !no_cull_reg && |(outside & mask3_reg);

    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            culled_reg <= culled_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, culled_reg};

    // checks
    `FBSC_ASSERT(a_stall_holds_s3, v3_reg && !rdy_out |=> v3_reg, "stage 3 item dropped under stall")
    `FBSC_NEVER(a_ready_only_full, !s_axis_tready && !(v1_reg && v2_reg && v3_reg && out_valid_reg), "input stalled with a free stage")
    `FBSC_ASSERT(a_empty_mask, v3_reg && rdy_out && mask3_reg == '0 |=> !m_axis_tdata[0], "culled with no plane enabled")

endmodule

/* rtl/fbsc_plane.sv */
// ----------------------------------------------------------------------------
// fbsc_plane
// Datapath for one frustum plane: operand select, multiply, accumulate.
// ----------------------------------------------------------------------------
module fbsc_plane
    import fbsc_pkg::*;
(
    input  logic                     aclk,
    input  fbsc_stage_en_t           en,
    input  logic [PLANE_W-1:0]       plane,
    input  logic                     opcode,
    input  logic signed [COORD_W-1:0] lo [3],
    input  logic signed [COORD_W-1:0] hi [3],
    input  logic signed [COORD_W-1:0] ctr [3],
    input  logic [COORD_W-1:0]       radius,
    output logic signed [ACC_W-1:0]  lhs,
    output logic signed [ACC_W-1:0]  rhs
);

    logic signed [NORM_W-1:0]  norm [3];
    logic signed [DIST_W-1:0]  plane_dist;

    logic signed [COORD_W-1:0] opnd_reg [3];
    logic signed [COORD_W-1:0] opnd_next [3];
    logic [COORD_W-1:0]        rad1_reg;
    logic                      op1_reg;

    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [PROD_W-1:0]  prod_next [3];
    logic [COORD_W-1:0]        rad2_reg;
    logic                      op2_reg;

    logic signed [ACC_W-1:0]   lhs_reg;
    logic signed [ACC_W-1:0]   lhs_next;
    logic signed [ACC_W-1:0]   rhs_reg;
    logic signed [ACC_W-1:0]   rhs_next;

    // plane fields
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            norm[k] = $signed(plane[k*NORM_W +: NORM_W]);
        end
        plane_dist = $signed(plane[DIST_LSB +: DIST_W]);
    end

    // stage 1: nearest-inside corner for a box, centre for a sphere
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (opcode == OP_SPHERE) begin
                opnd_next[k] = ctr[k];
            end else if (norm[k][NORM_W-1]) begin
                opnd_next[k] = lo[k];
            end else begin
                opnd_next[k] = hi[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.sel) begin
            opnd_reg <= opnd_next;
            rad1_reg <= radius;
            op1_reg  <= opcode;
        end
    end

    // stage 2: one product per axis
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = norm[k] * opnd_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            prod_reg <= prod_next;
            rad2_reg <= rad1_reg;
            op2_reg  <= op1_reg;
        end
    end

    // stage 3: dot product, radius folded in so both tests become lhs < rhs
    // sphere: dot + r*1024 <= dist  becomes  dot + r*1024 < dist + 1
    always_comb begin
        lhs_next = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2]);
        rhs_next = ACC_W'(plane_dist);
        if (op2_reg == OP_SPHERE) begin
            lhs_next = lhs_next + $signed({{(ACC_W-COORD_W-FRAC_BITS){1'b0}},
                                            rad2_reg, {FRAC_BITS{1'b0}}});
            rhs_next = rhs_next + ACC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.sum) begin
            lhs_reg <= lhs_next;
            rhs_reg <= rhs_next;
        end
    end

    assign lhs = lhs_reg;
    assign rhs = rhs_reg;

endmodule
